/* design/phd_pkg.sv */
// Package with phase codes, register indexes and constants of the pH dosing controller.
package phd_pkg;

	localparam int PHASE_W = 2;
	localparam logic [PHASE_W-1:0] PH_IDLE    = 2'd0;
	localparam logic [PHASE_W-1:0] PH_DOSING  = 2'd1;
	localparam logic [PHASE_W-1:0] PH_MIXING  = 2'd2;
	localparam logic [PHASE_W-1:0] PH_WAITING = 2'd3;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_CHECK_INTERVAL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WAIT_INTERVAL  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIX_DURATION   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LOWER_LIMIT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_UPPER_LIMIT    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET         = 3'd5;

	localparam int INTERVAL_W = 20;
	localparam int LIMIT_W    = 8;
	localparam int SAMPLE_W   = 10;
	localparam int DOSE_W     = 16;
	localparam int PH_W       = 4;
	localparam int PH_MAX     = 14;
	localparam int SCALED_W   = 20;

	localparam logic [INTERVAL_W-1:0] CHECK_INTERVAL_RST = 20'd30000;
	localparam logic [INTERVAL_W-1:0] WAIT_INTERVAL_RST  = 20'd18000;
	localparam logic [INTERVAL_W-1:0] MIX_DURATION_RST   = 20'd1000;
	localparam logic [LIMIT_W-1:0]    LOWER_LIMIT_RST    = 8'd55;
	localparam logic [LIMIT_W-1:0]    UPPER_LIMIT_RST    = 8'd65;
	localparam logic [LIMIT_W-1:0]    TARGET_RST         = 8'd60;

	typedef struct packed {
		logic                  acid;
		logic                  base;
		logic                  mix;
		logic [PHASE_W-1:0]    phase;
		logic [PH_W-1:0]       ph;
		logic                  checked;
	} phd_result_t;

endpackage

/* design/ph_dosing_controller.sv */
// Top level of the pH dosing controller: input register, tick logic and result register.
//
// Each accepted transfer is one 1 ms tick; it yields exactly one result transfer. The block
// takes one tick per clock cycle unless out_ready holds back the result register: the tick's
// sample and dose time sit in an input register, one pass of compare-and-count logic updates
// the phase, the time-since-check counter and the mixing counter, and the result lands in an
// output register, and a new tick is taken while the previous result waits. Configuration
// writes are taken at once and are meant to arrive only while no tick is in flight.
module ph_dosing_controller
	import phd_pkg::*;
#(
	parameter int ADC_MAX    = 1023,
	parameter int TIMER_BITS = 20
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [INTERVAL_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [SAMPLE_W-1:0]   ph_sample,
	input  logic [DOSE_W-1:0]     dose_duration_ms,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  acid_pump_on,
	output logic                  base_pump_on,
	output logic                  mix_pump_on,
	output logic [PHASE_W-1:0]    phase_now,
	output logic [PH_W-1:0]       ph_value,
	output logic                  check_done
);

	localparam int CW = (TIMER_BITS > INTERVAL_W) ? TIMER_BITS : INTERVAL_W;

	logic [INTERVAL_W-1:0] check_interval_q;
	logic [INTERVAL_W-1:0] wait_interval_q;
	logic [INTERVAL_W-1:0] mix_duration_q;
	logic [LIMIT_W-1:0]    lower_limit_q;
	logic [LIMIT_W-1:0]    upper_limit_q;
	logic [LIMIT_W-1:0]    target_q;

	logic [PHASE_W-1:0]    phase_q;
	logic [TIMER_BITS-1:0] tsc_q;
	logic [INTERVAL_W-1:0] mix_rem_q;
	logic                  base_q;
	logic [PH_W-1:0]       last_ph_q;

	logic                  valid_s1;
	logic [SAMPLE_W-1:0]   sample_s1;
	logic [DOSE_W-1:0]     dose_s1;

	logic                  out_valid_q;
	phd_result_t           result_q;

	logic                  advance;
	logic [PH_W-1:0]       ph_scaled;
	logic [LIMIT_W-1:0]    tenths;
	logic [PHASE_W-1:0]    phase_d;
	logic [TIMER_BITS-1:0] elapsed;
	logic [TIMER_BITS-1:0] tsc_d;
	logic [INTERVAL_W-1:0] mix_rem_d;
	logic                  base_d;
	logic [PH_W-1:0]       last_ph_d;
	logic                  checked;
	phd_result_t           result_d;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;

	phd_scale #(
		.ADC_MAX(ADC_MAX)
	) u_scale (
		.sample(sample_s1),
		.ph    (ph_scaled)
	);

	assign tenths = LIMIT_W'(ph_scaled) * LIMIT_W'(10);

	always_comb begin
		phase_d   = phase_q;
		mix_rem_d = mix_rem_q;
		base_d    = base_q;
		last_ph_d = last_ph_q;
		elapsed   = tsc_q;
		checked   = 1'b0;

		if (phase_d == PH_MIXING) begin
			if (mix_rem_q == '0) begin
				phase_d = PH_WAITING;
			end else begin
				mix_rem_d = mix_rem_q - 1'b1;
			end
		end

		if ((phase_d == PH_IDLE && CW'(tsc_q) >= CW'(check_interval_q)) ||
		    (phase_d == PH_WAITING && CW'(tsc_q) >= CW'(wait_interval_q))) begin
			checked   = 1'b1;
			elapsed   = '0;
			last_ph_d = ph_scaled;
			if (tenths < lower_limit_q || tenths > upper_limit_q) begin
				base_d  = (tenths < target_q);
				phase_d = PH_DOSING;
			end else begin
				phase_d = PH_IDLE;
			end
		end

		if (phase_d == PH_DOSING && CW'(elapsed) >= CW'(dose_s1)) begin
			if (mix_duration_q == '0) begin
				phase_d   = PH_WAITING;
				mix_rem_d = '0;
			end else begin
				phase_d   = PH_MIXING;
				mix_rem_d = mix_duration_q - 1'b1;
			end
		end

		tsc_d = (elapsed == '1) ? elapsed : elapsed + 1'b1;

		result_d.acid    = (phase_d == PH_DOSING) && !base_d;
		result_d.base    = (phase_d == PH_DOSING) && base_d;
		result_d.mix     = (phase_d == PH_MIXING);
		result_d.phase   = phase_d;
		result_d.ph      = last_ph_d;
		result_d.checked = checked;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_interval_q <= CHECK_INTERVAL_RST;
			wait_interval_q  <= WAIT_INTERVAL_RST;
			mix_duration_q   <= MIX_DURATION_RST;
			lower_limit_q    <= LOWER_LIMIT_RST;
			upper_limit_q    <= UPPER_LIMIT_RST;
			target_q         <= TARGET_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_CHECK_INTERVAL: check_interval_q <= cfg_data;
				CFG_WAIT_INTERVAL:  wait_interval_q  <= cfg_data;
				CFG_MIX_DURATION:   mix_duration_q   <= cfg_data;
				CFG_LOWER_LIMIT:    lower_limit_q    <= cfg_data[LIMIT_W-1:0];
				CFG_UPPER_LIMIT:    upper_limit_q    <= cfg_data[LIMIT_W-1:0];
				CFG_TARGET:         target_q         <= cfg_data[LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			tsc_q     <= '0;
			mix_rem_q <= '0;
			base_q    <= 1'b0;
			last_ph_q <= '0;
		end else if (advance) begin
			phase_q   <= phase_d;
			tsc_q     <= tsc_d;
			mix_rem_q <= mix_rem_d;
			base_q    <= base_d;
			last_ph_q <= last_ph_d;
		end
	end

	// hold the tick until the result register can take it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_s1 <= ph_sample;
			dose_s1   <= dose_duration_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign acid_pump_on = result_q.acid;
	assign base_pump_on = result_q.base;
	assign mix_pump_on  = result_q.mix;
	assign phase_now    = result_q.phase;
	assign ph_value     = result_q.ph;
	assign check_done   = result_q.checked;

endmodule

/* design/phd_scale.sv */
// Scaling of a raw converter sample to a whole pH value, floor(sample * 14 / ADC_MAX), capped at 14.
module phd_scale
	import phd_pkg::*;
#(
	parameter int ADC_MAX = 1023
) (
	input  logic [SAMPLE_W-1:0] sample,
	output logic [PH_W-1:0]     ph
);

	logic [SCALED_W-1:0] prod;

	assign prod = SCALED_W'(sample) * SCALED_W'(PH_MAX);

	always_comb begin
		ph = '0;
		for (int k = 1; k <= PH_MAX; k++) begin
			if (prod >= SCALED_W'(k * ADC_MAX)) begin
				ph = PH_W'(k);
			end
		end
	end

endmodule
